FILE: rtl/core/uraf_pkg.sv
// ----------------------------------------------------------------------------
// uraf_pkg
// Shared types and protocol constants for the UART register access framer.
// ----------------------------------------------------------------------------
package uraf_pkg;

    // Frame header and operation codes.
    localparam logic [7:0] HDR_REQUEST   = 8'hAA;
    localparam logic [7:0] HDR_STATUS    = 8'hEE;
    localparam logic [7:0] HDR_DATA      = 8'hBB;
    localparam logic [7:0] OP_READ       = 8'h01;
    localparam logic [7:0] OP_WRITE      = 8'h00;
    localparam logic [7:0] CODE_READ_OK  = 8'h00;
    localparam logic [7:0] CODE_WRITE_OK = 8'h01;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_RX_BYTE   = 2'd0,
        CMD_READ_REQ  = 2'd1,
        CMD_WRITE_HDR = 2'd2,
        CMD_WRITE_PAY = 2'd3
    } t_cmd;

    // Result kind codes.
    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // Receive phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    // All results caused by one word. Only out_byte differs between
    // the results of one batch; last_pos is the index of the final one.
    typedef struct packed {
        logic            has_res;
        logic [1:0]      last_pos;
        t_kind           kind;
        logic [3:0][7:0] bytes;
        logic [7:0]      data_index;
        logic [7:0]      status;
        logic            ok;
        logic            done_res;
    } t_batch;

endpackage

FILE: rtl/core/uraf_deframer.sv
// ----------------------------------------------------------------------------
// uraf_deframer
// Protocol state and per-word result computation. Builds the batch of
// results for the word held in the input register and updates the
// deframer state when that word is taken.
// ----------------------------------------------------------------------------
module uraf_deframer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [1:0]      i_command,
    input  logic [7:0]      i_byte_value,
    input  logic [7:0]      i_reg_address,
    input  logic [7:0]      i_length,
    output uraf_pkg::t_batch o_batch
);
    import uraf_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_status_reply, n_status_reply;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_index, n_index;
    logic       r_pend_wr, n_pend_wr;
    logic [7:0] expected;
    logic [7:0] rem_dec;
    t_batch     batch;

    assign expected = r_pend_wr ? CODE_WRITE_OK : CODE_READ_OK;
    assign rem_dec  = r_remaining - 8'd1;

    // Next state and results for the current word.
    always_comb begin
        n_phase        = r_phase;
        n_status_reply = r_status_reply;
        n_remaining    = r_remaining;
        n_index        = r_index;
        n_pend_wr      = r_pend_wr;
        batch          = '0;
        batch.kind     = KIND_TX;
        case (t_cmd'(i_command))
            CMD_READ_REQ, CMD_WRITE_HDR: begin
                n_pend_wr      = (t_cmd'(i_command) == CMD_WRITE_HDR);
                batch.has_res  = 1'b1;
                batch.last_pos = 2'd3;
                batch.bytes[0] = HDR_REQUEST;
                batch.bytes[1] = n_pend_wr ? OP_WRITE : OP_READ;
                batch.bytes[2] = i_reg_address;
                batch.bytes[3] = i_length;
            end
            CMD_WRITE_PAY: begin
                batch.has_res  = 1'b1;
                batch.bytes[0] = i_byte_value;
            end
            default: begin
                unique case (r_phase)
                    PH_LEN: begin
                        if (r_status_reply) begin
                            // Status reply completes the transaction.
                            n_phase        = PH_IDLE;
                            batch.has_res  = 1'b1;
                            batch.kind     = KIND_DONE;
                            batch.status   = i_byte_value;
                            batch.ok       = (i_byte_value == expected);
                            batch.done_res = 1'b1;
                        end else begin
                            n_remaining = i_byte_value;
                            n_index     = 8'd0;
                            if (i_byte_value == 8'd0) begin
                                // Empty data reply completes at once.
                                n_phase        = PH_IDLE;
                                batch.has_res  = 1'b1;
                                batch.kind     = KIND_DONE;
                                batch.ok       = !r_pend_wr;
                                batch.done_res = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_remaining      = rem_dec;
                        n_index          = r_index + 8'd1;
                        if (rem_dec == 8'd0) begin
                            n_phase = PH_IDLE;
                        end
                        batch.has_res    = 1'b1;
                        batch.kind       = KIND_DATA;
                        batch.bytes[0]   = i_byte_value;
                        batch.data_index = r_index;
                        batch.ok         = !r_pend_wr;
                        batch.done_res   = (rem_dec == 8'd0);
                    end
                    default: begin
                        // Awaiting a header byte; others are dropped.
                        if (i_byte_value == HDR_STATUS) begin
                            n_status_reply = 1'b1;
                            n_phase        = PH_LEN;
                        end else if (i_byte_value == HDR_DATA) begin
                            n_status_reply = 1'b0;
                            n_phase        = PH_LEN;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
        endcase
    end

    assign o_batch = batch;

    // State registers, advanced only when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_status_reply <= 1'b0;
            r_remaining    <= 8'd0;
            r_index        <= 8'd0;
            r_pend_wr      <= 1'b0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_status_reply <= n_status_reply;
            r_remaining    <= n_remaining;
            r_index        <= n_index;
            r_pend_wr      <= n_pend_wr;
        end
    end

    // The data phase is never entered with nothing left to receive.
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != 8'd0))
        else $error("data phase with zero bytes remaining");

    // A data reply starts at index zero.
    a_index_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_phase) == PH_LEN && r_phase == PH_DATA) |-> (r_index == 8'd0))
        else $error("data reply did not start at index zero");

    // The data phase can only follow the length phase or itself.
    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA && $past(r_phase) != PH_DATA)
            |-> ($past(r_phase) == PH_LEN))
        else $error("data phase entered without a length");

endmodule

FILE: rtl/core/uraf_out_seq.sv
// ----------------------------------------------------------------------------
// uraf_out_seq
// Result register. Holds one batch and sends its results one word per
// cycle while i_stall is low, marking the final one.
// ----------------------------------------------------------------------------
module uraf_out_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  uraf_pkg::t_batch i_batch,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic [7:0]       o_data_index,
    output logic [7:0]       o_status,
    output logic             o_ok,
    output logic             o_done_res,
    output logic             o_last
);
    import uraf_pkg::*;

    t_batch     r_buf;
    logic       r_valid;
    logic [1:0] r_pos;
    logic       is_last;
    logic       fire;

    assign is_last = (r_pos == r_buf.last_pos);
    assign fire    = r_valid && !i_stall;
    assign o_free  = !r_valid || (fire && is_last);

    // Batch holding and position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pos   <= 2'd0;
        end else if (fire) begin
            if (is_last) begin
                r_valid <= 1'b0;
                r_pos   <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch;
        end
    end

    // Output fields.
    assign o_valid      = r_valid;
    assign o_kind       = r_buf.kind;
    assign o_out_byte   = r_buf.bytes[r_pos];
    assign o_data_index = r_buf.data_index;
    assign o_status     = r_buf.status;
    assign o_ok         = r_buf.ok;
    assign o_done_res   = r_buf.done_res;
    assign o_last       = is_last;

    // A new batch never overwrites one still being sent.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("batch loaded while results pending");

    // Only transmit batches have more than one result.
    a_multi_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_buf.last_pos != 2'd0) |-> (r_buf.kind == KIND_TX))
        else $error("multi-result batch is not a transmit batch");

    // Position never runs past the final result.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_pos <= r_buf.last_pos))
        else $error("result position beyond batch end");

endmodule

FILE: rtl/core/uart_register_access_framer.sv
// ----------------------------------------------------------------------------
// uart_register_access_framer
// Host side of a byte-framed UART register protocol: frames read and
// write requests and deframes status and data replies.
//
//   Channel | Direction | Handshake          | Fields
//   --------+-----------+--------------------+--------------------------------
//   in      | to block  | i_valid / o_stall  | command, byte_value,
//           |           |                    | reg_address, length
//   out     | from block| o_valid / i_stall  | kind, out_byte, data_index,
//           |           |                    | status, ok, done_res, last
//
// A word is accepted into the input register, turned combinationally into a
// batch of results and loaded into the result register once that is free, so
// its results can be sent. A payload byte gives one result, a received byte at
// most one and a request four, sent one per cycle while i_stall is low. A word
// that gives results waits for the result register to free; header bytes that
// give none never wait. Reset is synchronous.
// ----------------------------------------------------------------------------
module uart_register_access_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_reg_address,
    input  logic [7:0] i_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_data_index,
    output logic [7:0] o_status,
    output logic       o_ok,
    output logic       o_done_res,
    output logic       o_last
);
    import uraf_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_command;
    logic [7:0] r_byte_value;
    logic [7:0] r_reg_address;
    logic [7:0] r_length;
    t_batch     batch;
    logic       out_free;
    logic       take;
    logic       load;

    // Input register.
    assign take    = r_in_valid && (!batch.has_res || out_free);
    assign load    = take && batch.has_res;
    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_command     <= i_command;
            r_byte_value  <= i_byte_value;
            r_reg_address <= i_reg_address;
            r_length      <= i_length;
        end
    end

    // Protocol state and result computation.
    uraf_deframer u_deframer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_command     (r_command),
        .i_byte_value  (r_byte_value),
        .i_reg_address (r_reg_address),
        .i_length      (r_length),
        .o_batch       (batch)
    );

    // Result register and sequencer.
    uraf_out_seq u_out_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_batch      (batch),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_data_index (o_data_index),
        .o_status     (o_status),
        .o_ok         (o_ok),
        .o_done_res   (o_done_res),
        .o_last       (o_last)
    );

    // A word is only taken from a full input register.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_in_valid)
        else $error("word taken from empty input register");

    // Receive results are always single and final.
    a_rx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_DATA || o_kind == KIND_DONE)) |-> o_last)
        else $error("receive result not marked last");

    // Transmit results never report completion.
    a_tx_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_TX) |-> (!o_done_res && !o_ok))
        else $error("transmit result carries completion");

endmodule
